// ===== hdl/overwrite_ring_buffer_hold_last_assert.svh =====
// ----------------------------------------------------------------------------
// overwrite ring buffer assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_RING_BUFFER_HOLD_LAST_ASSERT_SVH
`define OVERWRITE_RING_BUFFER_HOLD_LAST_ASSERT_SVH

// condition holds at every edge
`define ORB_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define ORB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ORB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/orb_pkg.sv =====
// ----------------------------------------------------------------------------
// orb_pkg
// shared codes, field widths and controller/datapath interface types
// ----------------------------------------------------------------------------
package orb_pkg;

  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int CAP_W    = 13;

  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic cfg_write;
    logic push;
    logic clear;
    logic start;
    logic fetch;
    logic load_mem;
    logic end_stored;
    logic load_pad;
  } orb_cmd_t;

  typedef struct packed {
    logic fill_empty;
    logic remain_zero;
    logic out_free;
  } orb_status_t;

endpackage

// ===== hdl/orb_ram.sv =====
// ----------------------------------------------------------------------------
// orb_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module orb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/orb_ctrl.sv =====
// ----------------------------------------------------------------------------
// orb_ctrl
// request sequencer: accepts requests and steps a read through fetch,
// load and padding phases
// ----------------------------------------------------------------------------
module orb_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [orb_pkg::ACTION_W-1:0]  action,
  input  logic                          len_nonzero,
  input  orb_pkg::orb_status_t          status,
  output orb_pkg::orb_cmd_t             cmd
);

  import orb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_PAD
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        cfg_ready     = 1'b1;
        in_ready      = !cfg_valid;
        cmd.cfg_write = cfg_valid;
        if (accept) begin
          case (action)
            ACT_WRITE: cmd.push = 1'b1;
            ACT_CLEAR: cmd.clear = 1'b1;
            ACT_READ: begin
              if (len_nonzero) begin
                cmd.start  = 1'b1;
                state_next = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        if (!status.fill_empty && !status.remain_zero) begin
          cmd.fetch  = 1'b1;
          state_next = ST_LOAD;
        end else begin
          cmd.end_stored = 1'b1;
          state_next     = ST_PAD;
        end
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.load_mem = 1'b1;
          state_next   = ST_FETCH;
        end
      end
      ST_PAD: begin
        if (status.remain_zero) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.load_pad = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/orb_datapath.sv =====
// ----------------------------------------------------------------------------
// orb_datapath
// byte store, pointers, fill count, held sample, read counter and output
// register, driven by sequencer commands
// ----------------------------------------------------------------------------
module orb_datapath #(
  parameter int DEPTH    = 4096,
  parameter int MAX_READ = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  orb_pkg::orb_cmd_t           cmd,
  output orb_pkg::orb_status_t        status,
  input  logic [orb_pkg::CAP_W-1:0]   cfg_data,
  input  logic [orb_pkg::BYTE_W-1:0]  data_byte,
  input  logic [orb_pkg::LEN_W-1:0]   read_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [orb_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last
);

  import orb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int REM_W = $clog2(MAX_READ + 1);

  logic [CNT_W-1:0]    capacity;
  logic [CNT_W-1:0]    cap_clamped;
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    fill;
  logic [2*BYTE_W-1:0] held;
  logic [BYTE_W-1:0]   prev_byte;
  logic [BYTE_W-1:0]   cur_byte;
  logic [1:0]          stored_cnt;
  logic [REM_W-1:0]    remain;
  logic [REM_W-1:0]    len_sat;
  logic                pad_phase;
  logic [BYTE_W-1:0]   rd_data;
  logic                empty_all;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= cap) ? '0 : PTR_W'(n);
  endfunction

  always_comb begin
    if (cfg_data == '0) begin
      cap_clamped = CNT_W'(1);
    end else if (32'(cfg_data) > DEPTH) begin
      cap_clamped = CNT_W'(DEPTH);
    end else begin
      cap_clamped = CNT_W'(cfg_data);
    end
  end

  assign len_sat   = (32'(read_length) > MAX_READ) ? REM_W'(MAX_READ) : REM_W'(read_length);
  assign empty_all = cmd.clear || cmd.cfg_write;

  assign status.fill_empty  = (fill == '0);
  assign status.remain_zero = (remain == '0);
  assign status.out_free    = !out_valid || out_ready;

  orb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_ptr),
    .wdata (data_byte),
    .re    (cmd.fetch),
    .raddr (rd_ptr),
    .rdata (rd_data)
  );

  // pointers, count, capacity and held sample
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(DEPTH);
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fill     <= '0;
      held     <= '0;
    end else if (empty_all) begin
      if (cmd.cfg_write) begin
        capacity <= cap_clamped;
      end
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      held   <= '0;
    end else begin
      if (cmd.push) begin
        wr_ptr <= advance(wr_ptr, capacity);
        if (fill >= capacity) begin
          rd_ptr <= advance(rd_ptr, capacity);
        end else begin
          fill <= fill + CNT_W'(1);
        end
      end
      if (cmd.fetch) begin
        rd_ptr <= advance(rd_ptr, capacity);
        fill   <= fill - CNT_W'(1);
      end
      if (cmd.end_stored && stored_cnt == 2'd2) begin
        held <= {cur_byte, prev_byte};
      end
    end
  end

  // read progress
  always_ff @(posedge clk) begin
    if (rst) begin
      remain     <= '0;
      stored_cnt <= '0;
      pad_phase  <= 1'b0;
    end else if (cmd.start) begin
      remain     <= len_sat;
      stored_cnt <= '0;
      pad_phase  <= 1'b0;
    end else if (cmd.load_mem) begin
      remain <= remain - REM_W'(1);
      if (stored_cnt != 2'd2) begin
        stored_cnt <= stored_cnt + 2'd1;
      end
    end else if (cmd.load_pad) begin
      remain    <= remain - REM_W'(1);
      pad_phase <= !pad_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mem) begin
      prev_byte <= cur_byte;
      cur_byte  <= rd_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_mem || cmd.load_pad) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mem) begin
      out_byte <= rd_data;
      out_last <= (remain == REM_W'(1));
    end else if (cmd.load_pad) begin
      out_byte <= pad_phase ? held[2*BYTE_W-1:BYTE_W] : held[BYTE_W-1:0];
      out_last <= (remain == REM_W'(1));
    end
  end

endmodule

// ===== hdl/overwrite_ring_buffer_hold_last.sv =====
// ----------------------------------------------------------------------------
// overwrite_ring_buffer_hold_last
// byte ring buffer that drops the oldest byte when full and pads short reads
// with the last 16-bit sample read from the store
// ----------------------------------------------------------------------------
// write and clear requests: one request per cycle while idle and no config write is pending
// read request of n bytes: each stored byte is a ram fetch, then a load of
//   the output register; each padding byte is a load of the output register;
//   loads wait for a free output register; the read returns to idle via ST_PAD
// reset: capacity DEPTH, buffer empty, held sample zero; no clearing pass
module overwrite_ring_buffer_hold_last #(
  parameter int DEPTH    = 4096,
  parameter int MAX_READ = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [23:0]                s_tdata,  // action[1:0], data_byte[9:2], read_length[16:10], zero
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,  // out_byte[7:0]
  output logic                       m_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [orb_pkg::CAP_W-1:0]  cfg_data
);

  import orb_pkg::*;

  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   data_byte;
  logic [LEN_W-1:0]    read_length;
  orb_cmd_t            cmd;
  orb_status_t         status;

  assign action      = s_tdata[ACTION_W-1:0];
  assign data_byte   = s_tdata[ACTION_W+BYTE_W-1:ACTION_W];
  assign read_length = s_tdata[ACTION_W+BYTE_W+LEN_W-1:ACTION_W+BYTE_W];

  orb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .action      (action),
    .len_nonzero (read_length != '0),
    .status      (status),
    .cmd         (cmd)
  );

  orb_datapath #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_data    (cfg_data),
    .data_byte   (data_byte),
    .read_length (read_length),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (m_tdata),
    .out_last    (m_tlast)
  );

`include "overwrite_ring_buffer_hold_last_assert.svh"

  `ORB_ASSERT_ALWAYS(a_cfg_req_apart, !(cfg_valid && cfg_ready && s_tvalid && s_tready), "config write and request taken together")
  `ORB_ASSERT_IMPLIES(a_fetch_has_data, cmd.fetch, !status.fill_empty && !status.remain_zero, "fetch from empty buffer or finished read")
  `ORB_ASSERT_NEXT(a_busy_after_start, cmd.start, !s_tready && !cfg_ready, "request accepted while read in progress")
  `ORB_ASSERT_ALWAYS(a_one_op, $onehot0({cmd.push, cmd.fetch, cmd.load_mem, cmd.load_pad}), "conflicting datapath commands")

endmodule
